// ===== rtl/core/lusl_pkg.sv =====
// Package with the types and constants shared by the longest unique run unit.
package lusl_pkg;

    localparam int MAX_LEN  = 65536;
    localparam int ALPHABET = 256;

    localparam int SYM_W = $clog2(ALPHABET);
    localparam int POS_W = 16;
    localparam int LEN_W = 17;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0] longest_length;
        logic             overflow;
    } t_out_item;

    function automatic logic [SYM_W-1:0] sym_of(input logic [7:0] code);
        return SYM_W'(code % ALPHABET);
    endfunction

endpackage

// ===== rtl/core/lusl_pos_ram.sv =====
// Single-port-write, single-port-read synchronous RAM for last positions.
module lusl_pos_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/longest_unique_substring_length_unit.sv =====
// Top level: longest run of distinct bytes in a streamed string.
//
// Bytes arrive one item per cycle, and a string is closed by an end item, which yields
// one result: the length of the longest run without a repeated byte and an overflow
// flag set when the string held more than MAX_LEN bytes (extra bytes are dropped).
// The unit sustains one item per clock: the last position of each byte value sits in
// a synchronous RAM read as the item is accepted, and the window update happens in the
// following cycle, with the write of the item just before forwarded past the RAM. The
// result is registered in the output register when the end item leaves the work stage. An
// end item stalls the input only while the previous result is still waiting in the
// output register. Seen bits live in flip-flops, so no clearing pass follows reset and
// the next string may start in the cycle after an end item.
module longest_unique_substring_length_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lusl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lusl_pkg::t_out_item o_out_item
);

    // Work stage registers.
    logic                         r_s1_vld;
    lusl_pkg::t_kind              r_s1_kind;
    logic [lusl_pkg::SYM_W-1:0]   r_s1_sym;
    logic                         r_fwd_hit;
    logic [lusl_pkg::POS_W-1:0]   r_fwd_pos;

    // String state.
    logic [lusl_pkg::ALPHABET-1:0] r_seen;
    logic [lusl_pkg::POS_W-1:0]    r_win_start;
    logic [lusl_pkg::LEN_W-1:0]    r_next_pos;
    logic [lusl_pkg::LEN_W-1:0]    r_best;
    logic                          r_ovf;

    logic                r_out_vld;
    lusl_pkg::t_out_item r_out_item;

    logic                       in_acc;
    logic                       s1_go;
    logic                       s1_char;
    logic                       s1_end;
    logic                       full;
    logic                       wr_en;
    logic [lusl_pkg::SYM_W-1:0] in_sym;
    logic [lusl_pkg::POS_W-1:0] rd_pos;
    logic [lusl_pkg::POS_W-1:0] last_pos;
    logic                       hit;

    logic [lusl_pkg::POS_W-1:0] n_win_start;
    logic [lusl_pkg::LEN_W-1:0] n_next_pos;
    logic [lusl_pkg::LEN_W-1:0] run;

    assign in_sym  = lusl_pkg::sym_of(i_in_item.char_code);
    assign s1_char = r_s1_vld && (r_s1_kind == lusl_pkg::KIND_CHAR);
    assign s1_end  = r_s1_vld && (r_s1_kind == lusl_pkg::KIND_END);
    assign s1_go   = s1_char || (s1_end && (!r_out_vld || i_out_ready));
    assign o_in_ready = !r_s1_vld || s1_go;
    assign in_acc  = i_in_valid && o_in_ready;

    assign full  = (r_next_pos >= lusl_pkg::LEN_W'(lusl_pkg::MAX_LEN));
    assign wr_en = s1_char && !full;

    lusl_pos_ram #(
        .DEPTH (lusl_pkg::ALPHABET),
        .WIDTH (lusl_pkg::POS_W)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_sym),
        .i_wr_data (r_next_pos[lusl_pkg::POS_W-1:0]),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_sym),
        .o_rd_data (rd_pos)
    );

    // The RAM returns the old entry when the item ahead writes the same address in
    // the cycle of the read, so that write is taken from the forwarding register.
    assign last_pos = r_fwd_hit ? r_fwd_pos : rd_pos;
    assign hit      = r_seen[r_s1_sym] && (last_pos >= r_win_start);

    always_comb begin
        n_win_start = hit ? (last_pos + 1'b1) : r_win_start;
        n_next_pos  = r_next_pos + 1'b1;
        run         = n_next_pos - lusl_pkg::LEN_W'(n_win_start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_seen      <= '0;
            r_win_start <= '0;
            r_next_pos  <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end

            if (s1_go && s1_end) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (s1_go && s1_char) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_seen[r_s1_sym] <= 1'b1;
                    r_win_start      <= n_win_start;
                    r_next_pos       <= n_next_pos;
                    if (run > r_best) begin
                        r_best <= run;
                    end
                end
            end else if (s1_go && s1_end) begin
                r_seen      <= '0;
                r_win_start <= '0;
                r_next_pos  <= '0;
                r_best      <= '0;
                r_ovf       <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= i_in_item.kind;
            r_s1_sym  <= in_sym;
            r_fwd_hit <= wr_en && (r_s1_sym == in_sym);
            r_fwd_pos <= r_next_pos[lusl_pkg::POS_W-1:0];
        end
        if (s1_go && s1_end) begin
            r_out_item.longest_length <= r_best;
            r_out_item.overflow       <= r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/lusl_checker.sv =====
// Port-level checker for the longest unique run unit, bound to the top level.
module lusl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lusl_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lusl_pkg::t_out_item o_out_item
);

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // No result may be shown straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A run never exceeds the number of bytes that can be taken.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.longest_length <= 17'(lusl_pkg::MAX_LEN))
        else $error("length beyond string limit");

    // A truncated string holds bytes, so its longest run cannot be empty.
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow |-> o_out_item.longest_length != '0)
        else $error("overflow reported with empty run");

endmodule

bind longest_unique_substring_length_unit lusl_checker u_lusl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
